>>> hdl/slt_pkg.sv
// Shared types and constants for the seasonal limit table checker.
// Used by slt_level_track and seasonal_limit_table_checker; depends on nothing.
package slt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_LEVELS  = 4;

    localparam logic [8:0] DAYS_IN_YEAR  = 9'd365;
    localparam logic [5:0] WILDCARD_HOUR = 6'b111111;
    localparam logic signed [23:0] MISSING_RESET = -24'sd8387840;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [2:0] V_STORED  = 3'd0;
    localparam logic [2:0] V_FULL    = 3'd1;
    localparam logic [2:0] V_WITHIN  = 3'd2;
    localparam logic [2:0] V_BELOW   = 3'd3;
    localparam logic [2:0] V_ABOVE   = 3'd4;
    localparam logic [2:0] V_NOLIM   = 3'd5;
    localparam logic [2:0] V_MISSING = 3'd6;

    localparam logic [2:0] LEVEL_NONE = 3'd4;

    typedef struct packed {
        logic [23:0]        station;
        logic [15:0]        param;
        logic [5:0]         hour;
        logic [8:0]         day_from;
        logic [8:0]         day_to;
        logic signed [23:0] lower_limit;
        logic signed [23:0] upper_limit;
    } entry_t;

    typedef struct packed {
        logic [23:0] station;
        logic [15:0] param;
        logic [5:0]  hour;
        logic [8:0]  day;
    } lookup_t;

    typedef struct packed {
        logic               found;
        logic [8:0]         day_from;
        logic [8:0]         day_to;
        logic signed [23:0] lower_limit;
        logic signed [23:0] upper_limit;
    } best_t;

endpackage

>>> hdl/seasonal_limit_table_checker.sv
// Top level of the seasonal limit table checker: table memory, scan sequencer, verdict.
// Depends on slt_pkg and slt_level_track.
//
// An add transfer (tuser 0) appends one limit entry to a 64-slot single-port table and
// answers stored or table full; the verdict is registered on acceptance and the result
// register loads from it in the DONE state once free, after which the next item can be accepted.
// A check transfer (tuser 1) reads every used slot once through the memory's single port,
// one slot per cycle, while four trackers follow the four search levels side by side;
// the sequencer then steps through WAIT, DECIDE and DONE (an empty table skips the scan and
// goes straight to DECIDE), the result register loads in DONE once free and the next item can follow.
// A stalled result holds the final state until the result register is free.
// One item is in work at a time; the result register lets the next item be accepted
// while a result waits. The table is empty after reset, with no clearing pass.
module seasonal_limit_table_checker (
    input  logic         aclk,
    input  logic         aresetn,
    // station[23:0] param[39:24] hour[45:40] day[54:46] day_from[63:55]
    // day_to[72:64] lower_limit[96:73] upper_limit[120:97] value[144:121]
    input  logic [151:0] s_tdata,
    // op[0]
    input  logic [0:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // verdict[2:0] found_min[26:3] found_max[50:27] match_level[53:51]
    output logic [55:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  cfg_data,
    input  logic         cfg_valid,
    output logic         cfg_ready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    slt_pkg::entry_t  in_entry;
    logic             in_op;
    logic [8:0]       in_day;
    logic signed [23:0] in_value;

    logic [slt_pkg::CNT_W-1:0] count_reg, count_next;
    logic [slt_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      eval_reg;

    slt_pkg::entry_t mem [slt_pkg::TABLE_DEPTH];
    slt_pkg::entry_t rd_data_reg;
    logic                      mem_we;
    logic [slt_pkg::IDX_W-1:0] mem_addr;

    logic signed [23:0] thresh_reg;

    logic [23:0]        q_station_reg;
    logic [15:0]        q_param_reg;
    logic [5:0]         q_hour_reg;
    logic [8:0]         q_day_reg;
    logic signed [23:0] q_value_reg;

    slt_pkg::lookup_t key [slt_pkg::NUM_LEVELS];
    slt_pkg::best_t   best [slt_pkg::NUM_LEVELS];
    logic [slt_pkg::NUM_LEVELS-1:0] hit;
    logic scan_clear;

    logic [2:0]         res_verdict_reg, res_verdict_next;
    logic signed [23:0] res_min_reg, res_min_next;
    logic signed [23:0] res_max_reg, res_max_next;
    logic [2:0]         res_level_reg, res_level_next;

    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;

    logic accept_in;
    logic out_free;
    logic last_slot;
    logic table_full;

    slt_pkg::best_t sel;
    logic [2:0]     sel_level;
    logic           sel_any;
    logic           span_ok;

    assign in_op                = s_tuser[0];
    assign in_entry.station     = s_tdata[23:0];
    assign in_entry.param       = s_tdata[39:24];
    assign in_entry.hour        = s_tdata[45:40];
    assign in_day               = s_tdata[54:46];
    assign in_entry.day_from    = s_tdata[63:55];
    assign in_entry.day_to      = s_tdata[72:64];
    assign in_entry.lower_limit = s_tdata[96:73];
    assign in_entry.upper_limit = s_tdata[120:97];
    assign in_value             = s_tdata[144:121];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept_in = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign table_full = (count_reg >= slt_pkg::CNT_W'(slt_pkg::TABLE_DEPTH));
    assign last_slot  = ((slt_pkg::CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign scan_clear = accept_in && (in_op == slt_pkg::OP_CHECK);

    // Table memory: one port, write on add, read during scan.
    assign mem_we   = accept_in && (in_op == slt_pkg::OP_ADD) && !table_full;
    assign mem_addr = (state_reg == ST_SCAN) ? idx_reg : count_reg[slt_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= in_entry;
        end else begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= slt_pkg::MISSING_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thresh_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_clear) begin
            q_station_reg <= in_entry.station;
            q_param_reg   <= in_entry.param;
            q_hour_reg    <= in_entry.hour;
            q_day_reg     <= in_day;
            q_value_reg   <= in_value;
        end
    end

    assign key[0] = '{station: q_station_reg, param: q_param_reg,
                      hour: q_hour_reg, day: q_day_reg};
    assign key[1] = '{station: q_station_reg, param: q_param_reg,
                      hour: slt_pkg::WILDCARD_HOUR, day: q_day_reg};
    assign key[2] = '{station: 24'd0, param: q_param_reg,
                      hour: q_hour_reg, day: q_day_reg};
    assign key[3] = '{station: 24'd0, param: q_param_reg,
                      hour: slt_pkg::WILDCARD_HOUR, day: q_day_reg};

    for (genvar g = 0; g < slt_pkg::NUM_LEVELS; g++) begin : g_level
        slt_level_track u_track (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (scan_clear),
            .eval    (eval_reg),
            .entry   (rd_data_reg),
            .key     (key[g]),
            .best    (best[g])
        );
        assign hit[g] = best[g].found && (best[g].day_to >= q_day_reg);
    end

    // Pick the first level that matches.
    always_comb begin
        sel       = best[3];
        sel_level = 3'd3;
        sel_any   = |hit;
        if (hit[0]) begin
            sel       = best[0];
            sel_level = 3'd0;
        end else if (hit[1]) begin
            sel       = best[1];
            sel_level = 3'd1;
        end else if (hit[2]) begin
            sel       = best[2];
            sel_level = 3'd2;
        end
    end

    assign span_ok = (sel.day_from >= 9'd1) && (sel.day_from <= slt_pkg::DAYS_IN_YEAR)
                     && (sel.day_to >= 9'd1) && (sel.day_to <= slt_pkg::DAYS_IN_YEAR)
                     && (sel.day_from <= sel.day_to);

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        res_verdict_next = res_verdict_reg;
        res_min_next     = res_min_reg;
        res_max_next     = res_max_reg;
        res_level_next   = res_level_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    if (in_op == slt_pkg::OP_ADD) begin
                        res_min_next   = '0;
                        res_max_next   = '0;
                        res_level_next = 3'd0;
                        if (table_full) begin
                            res_verdict_next = slt_pkg::V_FULL;
                        end else begin
                            res_verdict_next = slt_pkg::V_STORED;
                            count_next       = count_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = '0;
                        state_next = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (last_slot) begin
                    state_next = ST_WAIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!sel_any) begin
                    res_verdict_next = slt_pkg::V_NOLIM;
                    res_min_next     = '0;
                    res_max_next     = '0;
                    res_level_next   = slt_pkg::LEVEL_NONE;
                end else begin
                    res_min_next   = sel.lower_limit;
                    res_max_next   = sel.upper_limit;
                    res_level_next = sel_level;
                    if (!span_ok) begin
                        res_verdict_next = slt_pkg::V_NOLIM;
                    end else if (q_value_reg <= thresh_reg) begin
                        res_verdict_next = slt_pkg::V_MISSING;
                    end else if (q_value_reg < sel.lower_limit) begin
                        res_verdict_next = slt_pkg::V_BELOW;
                    end else if (q_value_reg > sel.upper_limit) begin
                        res_verdict_next = slt_pkg::V_ABOVE;
                    end else begin
                        res_verdict_next = slt_pkg::V_WITHIN;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            eval_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            eval_reg  <= (state_reg == ST_SCAN);
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        res_verdict_reg <= res_verdict_next;
        res_min_reg     <= res_min_next;
        res_max_reg     <= res_max_next;
        res_level_reg   <= res_level_next;
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {2'b00, res_level_reg, res_max_reg, res_min_reg, res_verdict_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hdl/slt_level_track.sv
// Best-candidate tracker for one search level of the limit table scan.
// Depends on slt_pkg for entry_t, lookup_t and best_t.
module slt_level_track (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clear,
    input  logic            eval,
    input  slt_pkg::entry_t entry,
    input  slt_pkg::lookup_t key,
    output slt_pkg::best_t  best
);

    logic               found_reg, found_next;
    logic [8:0]         from_reg, to_reg;
    logic signed [23:0] lo_reg, hi_reg;
    logic               take;

    // Strict compare keeps the earliest slot on equal start days.
    assign take = eval
                  && (entry.station == key.station)
                  && (entry.param == key.param)
                  && (entry.hour == key.hour)
                  && (entry.day_from <= key.day)
                  && (!found_reg || (entry.day_from > from_reg));

    always_comb begin
        found_next = found_reg;
        if (clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !clear) begin
            from_reg <= entry.day_from;
            to_reg   <= entry.day_to;
            lo_reg   <= entry.lower_limit;
            hi_reg   <= entry.upper_limit;
        end
    end

    assign best.found       = found_reg;
    assign best.day_from    = from_reg;
    assign best.day_to      = to_reg;
    assign best.lower_limit = lo_reg;
    assign best.upper_limit = hi_reg;

endmodule

>>> hdl/slt_checker.sv
// Port-level checks for seasonal_limit_table_checker, bound to the top level.
// Depends on the top level's port list and on slt_pkg for the result codes.
module slt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [55:0]  m_tdata,
    input logic         m_tvalid,
    input logic         m_tready
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer changed");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= slt_pkg::V_MISSING)
                     && (m_tdata[53:51] <= slt_pkg::LEVEL_NONE))
        else $error("verdict or level out of range");

    a_add_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[2:0] == slt_pkg::V_STORED) || (m_tdata[2:0] == slt_pkg::V_FULL))
        |-> (m_tdata[53:3] == '0))
        else $error("add result carries limits or a level");

endmodule

bind seasonal_limit_table_checker slt_checker u_slt_checker (.*);

>>> test/tb_seasonal_limit_table_checker.sv
// Self-checking testbench for seasonal_limit_table_checker: directed table, then random phases.
// Predicts verdicts from its own limit table copy and missing threshold unless a row gives one.
// Depends on slt_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb_seasonal_limit_table_checker;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 30000;
    localparam int HOLD_LEN    = 400;
    localparam int PHASE_ITEMS = 360;
    localparam int NUM_PHASES  = 5;

    typedef struct packed {
        logic               op;
        logic [23:0]        station;
        logic [15:0]        param;
        logic [5:0]         hour;
        logic [8:0]         day;
        logic [8:0]         day_from;
        logic [8:0]         day_to;
        logic signed [23:0] lower_limit;
        logic signed [23:0] upper_limit;
        logic signed [23:0] value;
    } limit_item_t;

    typedef struct packed {
        logic [2:0]         verdict;
        logic signed [23:0] found_min;
        logic signed [23:0] found_max;
        logic [2:0]         match_level;
    } verdict_rec_t;

    typedef struct packed {
        limit_item_t  item;
        logic         known;
        verdict_rec_t want;
    } stim_row_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic [151:0] s_tdata   = '0;
    logic [0:0]   s_tuser   = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [55:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [23:0]  cfg_data  = '0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;

    logic [23:0]        lim_station [slt_pkg::TABLE_DEPTH];
    logic [15:0]        lim_param   [slt_pkg::TABLE_DEPTH];
    logic [5:0]         lim_hour    [slt_pkg::TABLE_DEPTH];
    logic [8:0]         lim_from    [slt_pkg::TABLE_DEPTH];
    logic [8:0]         lim_to      [slt_pkg::TABLE_DEPTH];
    logic signed [23:0] lim_min     [slt_pkg::TABLE_DEPTH];
    logic signed [23:0] lim_max     [slt_pkg::TABLE_DEPTH];
    int                 lim_count   = 0;
    logic signed [23:0] missing_thr = slt_pkg::MISSING_RESET;

    verdict_rec_t awaited_verdicts[$];
    stim_row_t    directed_rows[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           rx_cycle       = 0;
    int           hold_left      = 0;
    int           burst_left     = 4;
    logic [15:0]  ready_pattern  = '1;

    seasonal_limit_table_checker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int scan_level(logic [23:0] st, logic [15:0] pr, logic [5:0] hr,
                                      logic [8:0] dy);
        int best;
        best = -1;
        for (int i = 0; i < lim_count; i++) begin
            if (lim_station[i] == st && lim_param[i] == pr && lim_hour[i] == hr &&
                lim_from[i] <= dy) begin
                if (best < 0 || lim_from[i] > lim_from[best])
                    best = i;
            end
        end
        if (best >= 0 && lim_to[best] >= dy)
            return best;
        return -1;
    endfunction

    function automatic verdict_rec_t judge_item(limit_item_t it);
        verdict_rec_t r;
        int           slot;
        logic         valid;
        r    = '0;
        slot = -1;
        if (it.op == slt_pkg::OP_ADD) begin
            if (lim_count >= slt_pkg::TABLE_DEPTH) begin
                r.verdict = slt_pkg::V_FULL;
            end else begin
                lim_station[lim_count] = it.station;
                lim_param[lim_count]   = it.param;
                lim_hour[lim_count]    = it.hour;
                lim_from[lim_count]    = it.day_from;
                lim_to[lim_count]      = it.day_to;
                lim_min[lim_count]     = it.lower_limit;
                lim_max[lim_count]     = it.upper_limit;
                lim_count++;
                r.verdict = slt_pkg::V_STORED;
            end
            return r;
        end
        r.match_level = slt_pkg::LEVEL_NONE;
        for (int lvl = 0; lvl < slt_pkg::NUM_LEVELS && slot < 0; lvl++) begin
            slot = scan_level((lvl < 2) ? it.station : 24'd0, it.param,
                              lvl[0] ? slt_pkg::WILDCARD_HOUR : it.hour, it.day);
            if (slot >= 0)
                r.match_level = 3'(lvl);
        end
        if (slot < 0) begin
            r.verdict = slt_pkg::V_NOLIM;
            return r;
        end
        r.found_min = lim_min[slot];
        r.found_max = lim_max[slot];
        valid = lim_from[slot] >= 9'd1 && lim_from[slot] <= slt_pkg::DAYS_IN_YEAR &&
                lim_to[slot] >= 9'd1 && lim_to[slot] <= slt_pkg::DAYS_IN_YEAR &&
                lim_from[slot] <= lim_to[slot];
        if (!valid)
            r.verdict = slt_pkg::V_NOLIM;
        else if ($signed(it.value) <= $signed(missing_thr))
            r.verdict = slt_pkg::V_MISSING;
        else if ($signed(it.value) < $signed(r.found_min))
            r.verdict = slt_pkg::V_BELOW;
        else if ($signed(it.value) > $signed(r.found_max))
            r.verdict = slt_pkg::V_ABOVE;
        else
            r.verdict = slt_pkg::V_WITHIN;
        return r;
    endfunction

    function automatic limit_item_t draw_item();
        limit_item_t  it;
        logic [159:0] noise;
        int           s;
        int           lo;
        int           hi;
        int           v;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it    = noise[$bits(limit_item_t)-1:0];
        if ($urandom_range(0, 9) == 0)
            return it;
        it.op = ($urandom_range(0, 7) == 0) ? slt_pkg::OP_ADD : slt_pkg::OP_CHECK;
        case ($urandom_range(0, 5))
            0: it.station = 24'd0;
            1, 4: it.station = 24'd1;
            2: it.station = 24'd2;
            3: it.station = 24'hFFFFFF;
            default: it.station = 24'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: it.param = 16'd0;
            2: it.param = 16'hFFFF;
            default: it.param = 16'd3;
        endcase
        case ($urandom_range(0, 5))
            0, 4: it.hour = slt_pkg::WILDCARD_HOUR;
            1: it.hour = 6'd0;
            2: it.hour = 6'd12;
            3: it.hour = 6'd23;
            default: it.hour = 6'($urandom);
        endcase
        if (it.op == slt_pkg::OP_ADD) begin
            case ($urandom_range(0, 7))
                0: begin
                    it.day_from = 9'($urandom);
                    it.day_to   = 9'($urandom);
                end
                1: begin
                    it.day_from = 9'($urandom_range(1, 365));
                    it.day_to   = it.day_from;
                end
                default: begin
                    it.day_from = 9'($urandom_range(1, 365));
                    it.day_to   = 9'($urandom_range(int'(it.day_from), 365));
                end
            endcase
            lo = int'($urandom_range(0, 60000)) - 30000;
            hi = ($urandom_range(0, 9) == 0) ? lo - 100 : lo + int'($urandom_range(0, 20000));
            it.lower_limit = 24'(lo);
            it.upper_limit = 24'(hi);
            return it;
        end
        if (lim_count > 0 && $urandom_range(0, 9) < 7) begin
            s = $urandom_range(0, lim_count - 1);
            if ($urandom_range(0, 3) != 0)
                it.station = lim_station[s];
            if ($urandom_range(0, 3) != 0)
                it.hour = lim_hour[s];
            it.param = lim_param[s];
            case ($urandom_range(0, 7))
                0: it.day = lim_from[s];
                1: it.day = lim_to[s];
                2: it.day = lim_to[s] + 9'd1;
                3: it.day = lim_from[s] - 9'd1;
                default: it.day = 9'($urandom_range(1, 365));
            endcase
            case ($urandom_range(0, 7))
                0: v = int'(lim_min[s]);
                1: v = int'(lim_min[s]) - 1;
                2: v = int'(lim_max[s]);
                3: v = int'(lim_max[s]) + 1;
                4: v = int'(missing_thr);
                5: v = int'(missing_thr) + 1;
                6: v = int'($urandom_range(0, 80000)) - 40000;
                default: v = int'($signed(24'($urandom)));
            endcase
            it.value = 24'(v);
        end else begin
            if ($urandom_range(0, 9) != 0)
                it.day = 9'($urandom_range(1, 365));
            if ($urandom_range(0, 1) == 0)
                it.value = 24'(int'($urandom_range(0, 80000)) - 40000);
        end
        return it;
    endfunction

    task automatic offer(input limit_item_t it, input logic known, input verdict_rec_t want,
                         input logic last);
        verdict_rec_t calc;
        s_tuser  <= it.op;
        s_tdata  <= {7'b0, it.value, it.upper_limit, it.lower_limit, it.day_to, it.day_from,
                     it.day, it.hour, it.param, it.station};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        calc = judge_item(it);
        awaited_verdicts.insert(awaited_verdicts.size(), known ? want : calc);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 || last) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic set_threshold(input logic signed [23:0] thr);
        while (awaited_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_data  <= thr;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        missing_thr = thr;
    endtask

    task automatic put_add(input int st, input int pr, input int hr, input int df, input int dt,
                           input int lo, input int hi);
        stim_row_t row;
        row                       = '0;
        row.item.op               = slt_pkg::OP_ADD;
        row.item.station          = 24'(st);
        row.item.param            = 16'(pr);
        row.item.hour             = 6'(hr);
        row.item.day_from         = 9'(df);
        row.item.day_to           = 9'(dt);
        row.item.lower_limit      = 24'(lo);
        row.item.upper_limit      = 24'(hi);
        row.known                 = 1'b1;
        row.want.verdict          = slt_pkg::V_STORED;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic put_check(input int st, input int pr, input int hr, input int dy,
                             input int val, input logic known, input logic [2:0] vd,
                             input int mn, input int mx, input logic [2:0] lv);
        stim_row_t row;
        row                  = '0;
        row.item.op          = slt_pkg::OP_CHECK;
        row.item.station     = 24'(st);
        row.item.param       = 16'(pr);
        row.item.hour        = 6'(hr);
        row.item.day         = 9'(dy);
        row.item.value       = 24'(val);
        row.known            = known;
        row.want.verdict     = vd;
        row.want.found_min   = 24'(mn);
        row.want.found_max   = 24'(mx);
        row.want.match_level = lv;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial begin : stimulus
        logic signed [23:0] thr;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        put_check(5, 7, 3, 100, 0, 1'b1, slt_pkg::V_NOLIM, 0, 0, slt_pkg::LEVEL_NONE);
        put_add(5, 7, 3, 1, 365, -256, 256);
        put_check(5, 7, 3, 100, 0, 1'b1, slt_pkg::V_WITHIN, -256, 256, 3'd0);
        put_check(5, 7, 3, 1, -257, 1'b1, slt_pkg::V_BELOW, -256, 256, 3'd0);
        put_check(5, 7, 3, 365, 257, 1'b1, slt_pkg::V_ABOVE, -256, 256, 3'd0);
        put_check(5, 7, 3, 100, -8387840, 1'b1, slt_pkg::V_MISSING, -256, 256, 3'd0);
        put_check(5, 7, 3, 100, -8388608, 1'b1, slt_pkg::V_MISSING, -256, 256, 3'd0);
        put_check(5, 7, 3, 100, 8388607, 1'b1, slt_pkg::V_ABOVE, -256, 256, 3'd0);
        put_check(5, 7, 3, 366, 0, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);
        put_add(5, 7, -1, 100, 200, -8388608, 8388607);
        put_check(5, 7, 9, 150, 0, 1'b1, slt_pkg::V_WITHIN, -8388608, 8388607, 3'd1);
        put_add(0, 7, 9, 0, 365, 100, 200);
        put_check(6, 7, 9, 10, 150, 1'b1, slt_pkg::V_NOLIM, 100, 200, 3'd2);
        put_add(0, 7, -1, 365, 365, 1, 2);
        put_check(6, 7, 4, 365, 1, 1'b1, slt_pkg::V_WITHIN, 1, 2, 3'd3);
        put_check(0, 7, 9, 50, 150, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);
        put_add(5, 7, 3, 1, 50, 5, 6);
        put_check(5, 7, 3, 30, 0, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);
        put_add(5, 7, 3, 50, 60, 1000, 2000);
        put_check(5, 7, 3, 70, 1500, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);
        put_add(16777215, 65535, -32, 300, 400, -1, 1);
        put_check(16777215, 65535, -32, 390, 0, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);
        put_check(16777215, 65535, -32, 511, 0, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);
        put_add(9, 1, 0, 200, 100, 0, 0);
        put_check(9, 1, 0, 150, 0, 1'b0, slt_pkg::V_STORED, 0, 0, 3'd0);

        for (int i = 0; i < directed_rows.size(); i++)
            offer(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want,
                  i == directed_rows.size() - 1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: thr = 24'h800000;
                1: thr = 24'($urandom);
                2: thr = 24'h7FFFFF;
                3: thr = slt_pkg::MISSING_RESET;
                default: thr = 24'(int'($urandom_range(0, 40000)) - 20000);
            endcase
            set_threshold(thr);
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer(draw_item(), 1'b0, '0, n == PHASE_ITEMS - 1);
        end

        while (awaited_verdicts.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_cycle == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ready_pattern[0];
            if (rx_cycle % 48 == 0)
                ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                             : (16'($urandom) | 16'h0101);
            else
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    always @(posedge aclk) begin : watch_results
        verdict_rec_t seen;
        verdict_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.verdict     = m_tdata[2:0];
            seen.found_min   = m_tdata[26:3];
            seen.found_max   = m_tdata[50:27];
            seen.match_level = m_tdata[53:51];
            want             = '0;
            if (awaited_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: verdict %0d min %0d max %0d level %0d",
                             seen.verdict, seen.found_min, seen.found_max, seen.match_level);
            end else begin
                want = awaited_verdicts.pop_front();
                if (seen.verdict !== want.verdict || seen.found_min !== want.found_min ||
                    seen.found_max !== want.found_max ||
                    seen.match_level !== want.match_level) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.verdict, want.found_min, want.found_max,
                                 want.match_level, seen.verdict, seen.found_min,
                                 seen.found_max, seen.match_level);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
